### hdl/nqs_pkg.sv
// Shared types and constants for the n-queens solution generator.
`timescale 1ns / 1ps

package nqs_pkg;

   localparam int COL_W     = 4;     // one stack entry / one placement nibble
   localparam int PLACE_W   = 64;
   localparam int COUNT_W   = 24;
   localparam int BSZ_W     = 5;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;
   localparam int CSR_IDX_W = CSR_AW - 2;

   localparam logic [COUNT_W-1:0]   COUNT_MAX      = {COUNT_W{1'b1}};
   localparam logic [BSZ_W-1:0]     BSZ_RESET      = 5'd8;
   localparam logic [CSR_IDX_W-1:0] CSR_BOARD_SIZE = 1'b0;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_COL0,
      OP_PLACE,
      OP_NEXT_COL,
      OP_POP,
      OP_FOUND,
      OP_EXHAUST,
      OP_LOAD
   } nqs_op_type;

   typedef struct packed {
      nqs_op_type op;
      logic       found;
   } nqs_cmd_type;

   typedef struct packed {
      logic done;
      logic count_nz;
      logic row_at_n;
      logic row_zero;
      logic col_end;
      logic free;
   } nqs_status_type;

endpackage

### hdl/nqs_datapath.sv
// Search datapath: column stack, occupancy masks, counter and result register.
`timescale 1ns / 1ps

module nqs_datapath #(
   parameter int MAX_N = 16,
   localparam int ROW_W = $clog2(MAX_N + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  nqs_pkg::nqs_cmd_type          cmd,
   input  logic [ROW_W-1:0]              n,
   output nqs_pkg::nqs_status_type       status,
   output logic                          out_found,
   output logic                          out_exhausted,
   output logic [nqs_pkg::PLACE_W-1:0]   out_placement,
   output logic [nqs_pkg::COUNT_W-1:0]   out_count
);
   import nqs_pkg::*;

   localparam int IDX_W  = $clog2(MAX_N);
   localparam int DIAG_N = 2 * MAX_N - 1;
   localparam int DG_W   = $clog2(DIAG_N);

   logic [ROW_W-1:0]   row_ff, row_in;
   logic [ROW_W-1:0]   col_ff, col_in;
   logic [MAX_N-1:0]   cols_ff, cols_in;
   logic [DIAG_N-1:0]  diag_ff, diag_in;
   logic [DIAG_N-1:0]  anti_ff, anti_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               done_ff, done_in;
   logic [COL_W-1:0]   stack_ff [MAX_N];

   logic               found_ff;
   logic               exhausted_ff;
   logic [PLACE_W-1:0] placement_ff;
   logic [COUNT_W-1:0] out_count_ff;

   logic [IDX_W-1:0]   row_idx, col_idx, top_idx, tog_row, tog_col;
   logic [ROW_W-1:0]   top_row;
   logic [COL_W-1:0]   top_col;
   logic [DG_W-1:0]    chk_diag, chk_anti, tog_diag, tog_anti;
   logic [MAX_N-1:0]   col_hot;
   logic [DIAG_N-1:0]  diag_hot, anti_hot;
   logic [PLACE_W-1:0] placement_w;

   // free test at the current row / column
   assign row_idx  = row_ff[IDX_W-1:0];
   assign col_idx  = col_ff[IDX_W-1:0];
   assign chk_diag = DG_W'(row_idx) + DG_W'(MAX_N - 1) - DG_W'(col_idx);
   assign chk_anti = DG_W'(row_idx) + DG_W'(col_idx);

   // top of stack, used when backing up one row
   assign top_row = row_ff - ROW_W'(1);
   assign top_idx = top_row[IDX_W-1:0];
   assign top_col = stack_ff[top_idx];

   // toggle target: place at (row, col) or remove the queen of the row above
   always_comb begin
      if (cmd.op == OP_POP) begin
         tog_row = top_idx;
         tog_col = IDX_W'(top_col);
      end else begin
         tog_row = row_idx;
         tog_col = col_idx;
      end
   end

   assign tog_diag = DG_W'(tog_row) + DG_W'(MAX_N - 1) - DG_W'(tog_col);
   assign tog_anti = DG_W'(tog_row) + DG_W'(tog_col);
   assign col_hot  = MAX_N'(1) << tog_col;
   assign diag_hot = DIAG_N'(1) << tog_diag;
   assign anti_hot = DIAG_N'(1) << tog_anti;

   assign status.done     = done_ff;
   assign status.count_nz = (count_ff != '0);
   assign status.row_at_n = (row_ff == n);
   assign status.row_zero = (row_ff == '0);
   assign status.col_end  = (col_ff >= n);
   assign status.free     = !cols_ff[col_idx] && !diag_ff[chk_diag] && !anti_ff[chk_anti];

   always_comb begin
      row_in   = row_ff;
      col_in   = col_ff;
      cols_in  = cols_ff;
      diag_in  = diag_ff;
      anti_in  = anti_ff;
      count_in = count_ff;
      done_in  = done_ff;
      unique case (cmd.op)
         OP_CLEAR: begin
            row_in   = '0;
            col_in   = '0;
            cols_in  = '0;
            diag_in  = '0;
            anti_in  = '0;
            count_in = '0;
            done_in  = 1'b0;
         end
         OP_COL0: begin
            col_in = '0;
         end
         OP_PLACE: begin
            cols_in = cols_ff ^ col_hot;
            diag_in = diag_ff ^ diag_hot;
            anti_in = anti_ff ^ anti_hot;
            row_in  = row_ff + ROW_W'(1);
            col_in  = '0;
         end
         OP_NEXT_COL: begin
            col_in = col_ff + ROW_W'(1);
         end
         OP_POP: begin
            cols_in = cols_ff ^ col_hot;
            diag_in = diag_ff ^ diag_hot;
            anti_in = anti_ff ^ anti_hot;
            row_in  = top_row;
            col_in  = ROW_W'(top_col) + ROW_W'(1);
         end
         OP_FOUND: begin
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + COUNT_W'(1);
            end
         end
         OP_EXHAUST: begin
            done_in = 1'b1;
            row_in  = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         cols_ff  <= '0;
         diag_ff  <= '0;
         anti_ff  <= '0;
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         row_ff   <= row_in;
         col_ff   <= col_in;
         cols_ff  <= cols_in;
         diag_ff  <= diag_in;
         anti_ff  <= anti_in;
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   // placement from the stack, rows at or above n read as zero
   always_comb begin
      placement_w = '0;
      for (int k = 0; k < MAX_N; k++) begin
         if (ROW_W'(k) < n) begin
            placement_w[COL_W*k +: COL_W] = stack_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_PLACE) begin
         stack_ff[row_idx] <= COL_W'(col_ff);
      end
      if (cmd.op == OP_LOAD) begin
         found_ff     <= cmd.found;
         exhausted_ff <= done_ff;
         placement_ff <= cmd.found ? placement_w : '0;
         out_count_ff <= count_ff;
      end
   end

   assign out_found     = found_ff;
   assign out_exhausted = exhausted_ff;
   assign out_placement = placement_ff;
   assign out_count     = out_count_ff;

endmodule

### hdl/nqs_ctrl.sv
// Search controller: sequences clear, resume, place/backtrack steps and result load.
`timescale 1ns / 1ps

module nqs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_restart,
   output logic                    req_tready,
   input  logic                    cfg_wr,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  nqs_pkg::nqs_status_type status,
   output nqs_pkg::nqs_cmd_type    cmd
);
   import nqs_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_SEARCH,
      ST_RESP
   } state_type;

   state_type  state_ff, state_in;
   logic       found_ff, found_in;
   logic       valid_ff, valid_in;
   nqs_op_type op;

   // a CSR write clears the search this cycle, so req_tready is held low while it happens
   assign req_tready = (state_ff == ST_IDLE) && !cfg_wr;
   assign rsp_tvalid = valid_ff;
   assign cmd.op     = op;
   assign cmd.found  = found_ff;

   always_comb begin
      state_in = state_ff;
      found_in = found_ff;
      valid_in = valid_ff && !rsp_tready;
      op       = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (cfg_wr) begin
               op = OP_CLEAR;
            end else if (req_tvalid) begin
               if (req_restart) begin
                  op = OP_CLEAR;
               end
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (status.done) begin
               found_in = 1'b0;
               state_in = ST_RESP;
            end else if (status.count_nz && status.row_at_n) begin
               if (status.row_zero) begin
                  op       = OP_EXHAUST;
                  found_in = 1'b0;
                  state_in = ST_RESP;
               end else begin
                  op       = OP_POP;
                  state_in = ST_SEARCH;
               end
            end else begin
               op       = OP_COL0;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (status.row_at_n) begin
               op       = OP_FOUND;
               found_in = 1'b1;
               state_in = ST_RESP;
            end else if (!status.col_end) begin
               op = status.free ? OP_PLACE : OP_NEXT_COL;
            end else if (status.row_zero) begin
               op       = OP_EXHAUST;
               found_in = 1'b0;
               state_in = ST_RESP;
            end else begin
               op = OP_POP;
            end
         end
         ST_RESP: begin
            if (!valid_ff || rsp_tready) begin
               op       = OP_LOAD;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         found_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         found_ff <= found_in;
         valid_ff <= valid_in;
      end
   end

endmodule

### hdl/n_queens_solution_generator_unit.sv
// Top level of the n-queens solution generator: CSR block, controller and datapath.
`timescale 1ns / 1ps

// Usage
//  - Request channel (req_*): one bit, restart. restart=1 clears the search and
//    starts from row 0; restart=0 resumes after the last placement given.
//  - Response channel (rsp_*): one response per request: found, exhausted,
//    placement (column of row k at bits 4k+3..4k) and the saturating count.
//  - CSR: board_size at byte address 0 (reset 8, sizes above MAX_N act as
//    MAX_N). Any write to it also clears the search. Write only when idle.
//  - Flow: a request passes the start state, the search walk and the response
//    state; the walk is made of place/advance/backtrack steps, and the search unit
//    tests one (row, column) square or removes one queen per cycle. The
//    walk is skipped when it ends at once (already exhausted, empty board).
//  - One request at a time: req_tready is high only while idle and no CSR
//    write is in its access cycle. A finished response sits in the output
//    register; the next request is accepted while it waits, and its response
//    loads once the old one is taken.
//  - Reset clears the masks, row, counter and exhausted flag; no clearing pass.
//  - A stalled receiver just holds rsp_tvalid and data; nothing is dropped.
module n_queens_solution_generator_unit #(
   parameter int MAX_N = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [0] restart
   // response channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [87:0]                   rsp_tdata,   // [63:0] placement, [87:64] solution_number
   output logic [1:0]                    rsp_tuser,   // [0] found, [1] exhausted
   // CSR port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [nqs_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [nqs_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [nqs_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import nqs_pkg::*;

   localparam int ROW_W = $clog2(MAX_N + 1);

   logic [BSZ_W-1:0]     board_size_ff, board_size_in;
   logic [CSR_IDX_W-1:0] csr_index;
   logic                 csr_write;
   logic                 cfg_wr;
   logic [ROW_W-1:0]     n_eff;

   nqs_cmd_type          cmd;
   nqs_status_type       status;
   logic                 out_found, out_exhausted;
   logic [PLACE_W-1:0]   out_placement;
   logic [COUNT_W-1:0]   out_count;

   // CSR: one register; writes to unmapped addresses are dropped
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_AW-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg_wr     = csr_write && (csr_index == CSR_BOARD_SIZE);
   assign csr_prdata = (csr_index == CSR_BOARD_SIZE) ? CSR_DW'(board_size_ff) : '0;

   assign board_size_in = cfg_wr ? csr_pwdata[BSZ_W-1:0] : board_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         board_size_ff <= BSZ_RESET;
      end else begin
         board_size_ff <= board_size_in;
      end
   end

   // board size clamped to what the stack and masks hold
   assign n_eff = (board_size_ff > BSZ_W'(MAX_N)) ? ROW_W'(MAX_N) : ROW_W'(board_size_ff);

   nqs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_restart (req_tdata[0]),
      .req_tready  (req_tready),
      .cfg_wr      (cfg_wr),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .status      (status),
      .cmd         (cmd)
   );

   nqs_datapath #(
      .MAX_N (MAX_N)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .n             (n_eff),
      .status        (status),
      .out_found     (out_found),
      .out_exhausted (out_exhausted),
      .out_placement (out_placement),
      .out_count     (out_count)
   );

   assign rsp_tdata = {out_count, out_placement};
   assign rsp_tuser = {out_exhausted, out_found};

   // one request in flight: the cycle after an accept the block is busy
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while a search was still running");

   // a response without a placement reports exhaustion and an empty placement
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tuser[1] && (rsp_tdata[63:0] == '0)))
      else $error("not-found response without exhausted flag or with placement bits");

   // a placement always carries a nonzero solution count and no exhaustion
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> ((rsp_tdata[87:64] != '0) && !rsp_tuser[1]))
      else $error("placement given with zero count or exhausted flag set");

endmodule

### test/nqs_scoreboard.sv
// Response checker for the n-queens generator: tracks the search and compares every response.
`timescale 1ns / 1ps

module nqs_scoreboard #(
   parameter int MAX_N = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [0] restart
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [87:0]                   rsp_tdata,   // [63:0] placement, [87:64] solution_number
   input  logic [1:0]                    rsp_tuser,   // [0] found, [1] exhausted
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [nqs_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [nqs_pkg::CSR_DW-1:0]    csr_pwdata,
   input  logic                          csr_pready,
   output int                            mismatch_count,
   output int                            pending
);

   // at most two requests are ever outstanding; room to spare
   localparam int ANSWER_DEPTH = 8;

   typedef struct packed {
      logic                          found;
      logic                          exhausted;
      logic [nqs_pkg::PLACE_W-1:0]   placement;
      logic [nqs_pkg::COUNT_W-1:0]   count;
   } answer_type;

   // expected responses, ring indexed by running in/out counts
   answer_type  expected_answers [ANSWER_DEPTH];
   int unsigned answers_in;
   int unsigned answers_out;

   // search state
   logic [nqs_pkg::BSZ_W-1:0]   board_size;
   logic [nqs_pkg::COL_W-1:0]   queen_col [MAX_N];
   int unsigned                 row_now;
   logic [MAX_N-1:0]            col_busy;
   logic [2*MAX_N-2:0]          diag_busy;
   logic [2*MAX_N-2:0]          anti_busy;
   logic [nqs_pkg::COUNT_W-1:0] solutions;
   logic                        search_over;

   function automatic void clear_search();
      foreach (queen_col[i]) queen_col[i] = '0;
      row_now = 0;
      col_busy = '0;
      diag_busy = '0;
      anti_busy = '0;
      solutions = '0;
      search_over = 1'b0;
   endfunction

   function automatic void flip_square(int unsigned r, int unsigned c);
      col_busy[c] = ~col_busy[c];
      diag_busy[r + MAX_N - 1 - c] = ~diag_busy[r + MAX_N - 1 - c];
      anti_busy[r + c] = ~anti_busy[r + c];
   endfunction

   function automatic bit square_free(int unsigned r, int unsigned c);
      return !col_busy[c] && !diag_busy[r + MAX_N - 1 - c] && !anti_busy[r + c];
   endfunction

   // walk forward to the next full placement; 0 when the board has none left
   function automatic bit advance_search(int unsigned n);
      int unsigned r;
      int unsigned c;
      int unsigned k;
      r = row_now;
      c = 0;
      if (search_over) return 1'b0;
      if (solutions != 0 && r == n) begin
         if (r == 0) begin
            search_over = 1'b1;
            return 1'b0;
         end
         r--;
         c = queen_col[r];
         flip_square(r, c);
         c++;
      end
      while (1) begin
         if (r >= n) begin
            row_now = r;
            return 1'b1;
         end
         k = c;
         while (k < n && !square_free(r, k)) k++;
         if (k < n) begin
            flip_square(r, k);
            queen_col[r] = nqs_pkg::COL_W'(k);
            r++;
            c = 0;
         end else begin
            if (r == 0) begin
               row_now = 0;
               search_over = 1'b1;
               return 1'b0;
            end
            r--;
            k = queen_col[r];
            flip_square(r, k);
            c = k + 1;
         end
      end
      return 1'b0;
   endfunction

   function automatic answer_type next_answer();
      int unsigned n;
      answer_type a;
      n = (board_size > MAX_N) ? MAX_N : board_size;
      a = '0;
      a.found = advance_search(n);
      if (a.found) begin
         if (solutions != nqs_pkg::COUNT_MAX) solutions++;
         for (int k = 0; k < n; k++)
            a.placement[nqs_pkg::COL_W*k +: nqs_pkg::COL_W] = queen_col[k];
      end
      a.count = solutions;
      a.exhausted = search_over;
      return a;
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : track
      answer_type want;
      if (reset) begin
         board_size = nqs_pkg::BSZ_RESET;
         clear_search();
         answers_in = 0;
         answers_out = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (answers_in == answers_out) begin
               mismatch_count++;
               $display("%0t: response expected none, got found %b exhausted %b placement %h count %0d",
                        $time, rsp_tuser[0], rsp_tuser[1], rsp_tdata[63:0], rsp_tdata[87:64]);
            end else begin
               want = expected_answers[answers_out % ANSWER_DEPTH];
               answers_out++;
               check_field("found", 64'(want.found), 64'(rsp_tuser[0]));
               check_field("exhausted", 64'(want.exhausted), 64'(rsp_tuser[1]));
               check_field("placement", want.placement, rsp_tdata[63:0]);
               check_field("solution_number", 64'(want.count), 64'(rsp_tdata[87:64]));
            end
         end
         // a board_size write always restarts the search
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[nqs_pkg::CSR_AW-1:2] == nqs_pkg::CSR_BOARD_SIZE) begin
            board_size = csr_pwdata[nqs_pkg::BSZ_W-1:0];
            clear_search();
         end
         if (req_tvalid && req_tready) begin
            if (req_tdata[0]) clear_search();
            if (answers_in - answers_out >= ANSWER_DEPTH) begin
               mismatch_count++;
               $display("%0t: outstanding requests expected below %0d, got %0d",
                        $time, ANSWER_DEPTH, answers_in - answers_out + 1);
            end
            expected_answers[answers_in % ANSWER_DEPTH] = next_answer();
            answers_in++;
         end
      end
      pending = int'(answers_in - answers_out);
   end

endmodule

### test/tb.sv
// Top of the n-queens generator bench: clock, reset, request and CSR traffic, verdict.
`timescale 1ns / 1ps

module tb;

   localparam int MAX_N           = 16;
   localparam int RANDOM_REQUESTS = 600;
   // worst request is a first placement on a 16x16 board, well under this
   localparam int QUIET_LIMIT     = 2_000_000;

   // unmapped register slot, writes there must be ignored
   localparam logic [nqs_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 1'b1;

   // receiver behavior, switched at random between these modes
   typedef enum logic [1:0] {
      SINK_FAST,
      SINK_RANDOM,
      SINK_SLOW,
      SINK_TOGGLE
   } sink_mode_type;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_tvalid;
   logic                         req_tready;
   logic [7:0]                   req_tdata;   // [0] restart
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [87:0]                  rsp_tdata;   // [63:0] placement, [87:64] solution_number
   logic [1:0]                   rsp_tuser;   // [0] found, [1] exhausted
   logic                         csr_psel;
   logic                         csr_penable;
   logic                         csr_pwrite;
   logic [nqs_pkg::CSR_AW-1:0]   csr_paddr;
   logic [nqs_pkg::CSR_DW-1:0]   csr_pwdata;
   logic [nqs_pkg::CSR_DW-1:0]   csr_prdata;
   logic                         csr_pready;

   int            mismatch_count;
   int            pending;
   int unsigned   quiet_cycles = 0;
   int unsigned   burst_left = 0;
   int unsigned   sink_left = 0;
   sink_mode_type sink_mode = SINK_FAST;

   always #1 clock = ~clock;

   n_queens_solution_generator_unit #(
      .MAX_N(MAX_N)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   nqs_scoreboard #(
      .MAX_N(MAX_N)
   ) scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .pending        (pending)
   );

   // receiver: stretches of always-ready, coin-flip, mostly-stalled and toggling
   always @(posedge clock) begin
      if (sink_left == 0) begin
         sink_mode <= sink_mode_type'($urandom_range(0, 3));
         sink_left <= $urandom_range(1, 60);
      end else begin
         sink_left <= sink_left - 1;
      end
      case (sink_mode)
         SINK_FAST:   rsp_tready <= 1'b1;
         SINK_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
         SINK_SLOW:   rsp_tready <= ($urandom_range(0, 7) == 0);
         default:     rsp_tready <= ~rsp_tready;
      endcase
   end

   // watchdog: any handshake on any port resets the quiet count
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One request. Within a burst tvalid stays up on return so a back-to-back request keeps it
   // high; whoever goes next either raises it again or drops it (drain).
   task automatic send_request(input logic restart);
      req_tdata  <= {7'b0, restart};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (burst_left == 0) begin
         // end of burst: idle gap of random length
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         burst_left = $urandom_range(0, 12);
      end else begin
         burst_left--;
      end
   endtask

   // wait until every response is back, then a short pause before CSR traffic
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // setup + access; upper data bits are junk, only [4:0] of board_size count
   task automatic write_csr(input logic [nqs_pkg::CSR_IDX_W-1:0] idx,
                            input logic [nqs_pkg::BSZ_W-1:0] value);
      logic [nqs_pkg::CSR_DW-1:0] word;
      word = $urandom;
      word[nqs_pkg::BSZ_W-1:0] = value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin : stimulus
      int                         random_sent;
      int unsigned                pick;
      int unsigned                walk_len;
      logic [nqs_pkg::BSZ_W-1:0]  board;
      logic                       first_restart;

      random_sent = 0;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed ----
      // 8x8 from the reset value of board_size
      send_request(1'b1);
      send_request(1'b0);
      send_request(1'b0);
      // size 0: empty placement once, then exhausted; restart brings it back
      drain();
      write_csr(nqs_pkg::CSR_BOARD_SIZE, 5'd0);
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b1);
      // 1x1: single placement
      drain();
      write_csr(nqs_pkg::CSR_BOARD_SIZE, 5'd1);
      send_request(1'b0);
      send_request(1'b0);
      // 2x2 and 3x3 have no placement at all
      drain();
      write_csr(nqs_pkg::CSR_BOARD_SIZE, 5'd2);
      send_request(1'b1);
      send_request(1'b0);
      drain();
      write_csr(nqs_pkg::CSR_BOARD_SIZE, 5'd3);
      send_request(1'b0);
      // 4x4: two placements, then it must stay exhausted
      drain();
      write_csr(nqs_pkg::CSR_BOARD_SIZE, 5'd4);
      repeat (4) send_request(1'b0);
      // write to the unmapped slot must not restart the 5x5 search
      drain();
      write_csr(nqs_pkg::CSR_BOARD_SIZE, 5'd5);
      send_request(1'b0);
      send_request(1'b0);
      drain();
      write_csr(CSR_UNMAPPED, 5'd3);
      send_request(1'b0);
      // all-ones size clamps to 16
      drain();
      write_csr(nqs_pkg::CSR_BOARD_SIZE, 5'd31);
      send_request(1'b1);
      send_request(1'b0);

      // ---- random ----
      // Each walk: new board size, then a run of resumes with the odd restart.
      // Small boards get runs long enough to hit exhaustion; big ones are rare
      // and short since the first placement alone costs a lot of cycles.
      while (random_sent < RANDOM_REQUESTS) begin
         pick = $urandom_range(0, 39);
         if (pick == 0) begin
            board    = nqs_pkg::BSZ_W'($urandom_range(16, 31));
            walk_len = $urandom_range(1, 3);
         end else if (pick < 8) begin
            board    = nqs_pkg::BSZ_W'($urandom_range(9, 15));
            walk_len = $urandom_range(1, 15);
         end else begin
            board    = nqs_pkg::BSZ_W'($urandom_range(0, 8));
            walk_len = (board < 7) ? $urandom_range(1, 20) : $urandom_range(1, 100);
         end
         drain();
         if ($urandom_range(0, 7) == 0)
            write_csr(CSR_UNMAPPED, nqs_pkg::BSZ_W'($urandom_range(0, 31)));
         write_csr(nqs_pkg::CSR_BOARD_SIZE, board);
         first_restart = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < walk_len && random_sent < RANDOM_REQUESTS; i++) begin
            if (i == 0)
               send_request(first_restart);
            else
               send_request($urandom_range(0, 15) == 0);
            random_sent++;
         end
      end

      // ---- wrap up ----
      drain();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
